// File: sv/prgt_pkg.sv
// ----------------------------------------------------------------------------
// prgt_pkg
// shared types and constants of the parallel ray grid tracer
// ----------------------------------------------------------------------------
`default_nettype none
package prgt_pkg;
	localparam int GRID_DEF = 16;
	localparam int MAX_BINS = 64;

	localparam int ANG_W  = 16;
	localparam int DET_W  = 6;
	localparam int PIX_W  = 8;
	localparam int LEN_W  = 16;
	localparam int GS_W   = 5;
	localparam int PB_W   = 7;
	localparam int OFS_W  = 28;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 28;

	localparam int NUM_W  = 48;
	localparam int TRIG_W = 18;
	localparam int S_W    = 30;

	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [15:0] SIN_B = 16'd42048;
	localparam logic [12:0] SIN_C = 13'd4640;

	localparam logic [GS_W-1:0]  GRID_SIZE_RST   = 5'd16;
	localparam logic [PB_W-1:0]  PADDED_BINS_RST = 7'd23;
	localparam logic [OFS_W-1:0] RAY_OFFSET_RST  = 28'd655;

	typedef enum logic [CFG_IW-1:0] {
		REG_GRID_SIZE   = 2'd0,
		REG_PADDED_BINS = 2'd1,
		REG_RAY_OFFSET  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [GS_W-1:0]         grid_size;
		logic [PB_W-1:0]         padded_bins;
		logic signed [OFS_W-1:0] ray_offset;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_index;
		logic [LEN_W-1:0] seg_length;
		logic             last;
		logic             empty_res;
	} res_t;
endpackage
`default_nettype wire

// File: sv/prgt_div.sv
// ----------------------------------------------------------------------------
// prgt_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module prgt_div #(
	parameter int NW = 48,
	parameter int DW = 18
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic signed [DW-1:0] den,
	output logic                      done,
	output logic signed [NW-1:0]      quo
);
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [NW-1:0]    dq_q;
	logic             neg_q;
	logic [DW:0]      trial;
	logic             ge;
	logic [DW:0]      rem_n;

	always_comb begin
		trial = {rem_q, dq_q[NW-1]};
		ge    = trial >= {1'b0, den_q};
		rem_n = ge ? (trial - {1'b0, den_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= num[NW-1] ? NW'(-num) : NW'(num);
			den_q <= den[DW-1] ? DW'(-den) : DW'(den);
			rem_q <= '0;
			neg_q <= num[NW-1] ^ den[DW-1];
		end else if (busy_q) begin
			rem_q <= rem_n[DW-1:0];
			dq_q  <= {dq_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(dq_q) : $signed(dq_q);
endmodule
`default_nettype wire

// File: sv/prgt_isqrt.sv
// ----------------------------------------------------------------------------
// prgt_isqrt
// integer square root, floor, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module prgt_isqrt #(
	parameter int W = 44
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] val,
	output logic              done,
	output logic [W/2-1:0]    root
);
	localparam int RW    = W / 2;
	localparam int CNT_W = $clog2(RW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     val_q;
	logic [RW:0]      rem_q;
	logic [RW-1:0]    root_q;
	logic [RW+2:0]    r2;
	logic [RW+2:0]    trial;
	logic             ge;

	always_comb begin
		r2    = {rem_q, val_q[W-1:W-2]};
		trial = (RW + 3)'({root_q, 2'b01});
		ge    = r2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[W-3:0], 2'b00};
			rem_q  <= ge ? (RW + 1)'(r2 - trial) : (RW + 1)'(r2);
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// File: sv/prgt_core.sv
// ----------------------------------------------------------------------------
// prgt_core
// ray setup, grid line scan into crossing memories, merge and segment output
// ----------------------------------------------------------------------------
`default_nettype none
module prgt_core #(
	parameter int GRID = prgt_pkg::GRID_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [prgt_pkg::ANG_W-1:0]  angle,
	input  wire logic [prgt_pkg::DET_W-1:0]  detector_index,
	input  wire prgt_pkg::cfg_t              cfg,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output prgt_pkg::res_t                   res
);
	import prgt_pkg::*;

	localparam int CW   = $clog2(GRID) + 17;
	localparam int IW   = $clog2(GRID + 1);
	localparam int CNW  = $clog2(GRID + 2);
	localparam int SQW  = 2 * CW + 2;
	localparam int RTW  = SQW / 2;
	localparam int DEP  = 2 ** IW;
	localparam int SMW  = CW + 2;
	localparam int CLW  = SMW - 17;

	typedef enum logic [17:0] {
		ST_IDLE    = 18'b000000000000000001,
		ST_T1      = 18'b000000000000000010,
		ST_T2      = 18'b000000000000000100,
		ST_T3      = 18'b000000000000001000,
		ST_T4      = 18'b000000000000010000,
		ST_MUL     = 18'b000000000000100000,
		ST_DA      = 18'b000000000001000000,
		ST_WA      = 18'b000000000010000000,
		ST_DB      = 18'b000000000100000000,
		ST_WB      = 18'b000000001000000000,
		ST_NEXT    = 18'b000000010000000000,
		ST_FETCH   = 18'b000000100000000000,
		ST_PICK    = 18'b000001000000000000,
		ST_SQ      = 18'b000010000000000000,
		ST_RT_GO   = 18'b000100000000000000,
		ST_RT_WAIT = 18'b001000000000000000,
		ST_OUT     = 18'b010000000000000000,
		ST_EMPTY   = 18'b100000000000000000
	} state_t;

	state_t state_q, state_n;

	logic [ANG_W-1:0]        ang_q;
	logic [DET_W-1:0]        det_q;
	logic [14:0]             zs_q, zc_q, z2s_q, z2c_q;
	logic [16:0]             ts_q, tc_q;
	logic signed [TRIG_W-1:0] sn_q, cs_q;
	logic signed [S_W-1:0]   s_q;
	logic [GS_W-1:0]         n_q;
	logic signed [CW-1:0]    gl_q;
	logic signed [CW+TRIG_W-1:0] pa_q, pb_q;
	logic [CNW-1:0]          alen_q, blen_q, i_q, j_q;
	logic [2*CW-1:0]         mem_a [DEP];
	logic [2*CW-1:0]         mem_b [DEP];
	logic [2*CW-1:0]         rda_q, rdb_q;
	logic signed [CW-1:0]    px_q, py_q;
	logic [CW-1:0]           ux_q, uy_q;
	logic signed [SMW-1:0]   smx_q, smy_q;
	logic                    lastseg_q;
	logic [SQW-1:0]          sq_q;
	logic [PIX_W-1:0]        pix_q;

	// setup values
	logic [GS_W-1:0]  g;
	logic [PB_W-1:0]  p;
	logic [1:0]       qs, qc;
	logic [15:0]      ac;
	logic [14:0]      zs, zc;
	logic [29:0]      zzs, zzc;
	logic [27:0]      czs, czc;
	logic [31:0]      tzs, tzc, vzs, vzc;
	logic signed [TRIG_W-1:0] vs, vc;
	logic signed [S_W-1:0] s_w;
	logic signed [CW-1:0]  gl_w;
	logic signed [NUM_W-1:0] half_w, numa, numb, div_q;
	logic                  div_start, div_done, in_rng;
	logic signed [NUM_W-1:0] div_num;
	logic signed [TRIG_W-1:0] div_den;

	always_comb begin
		g  = (cfg.grid_size > GS_W'(GRID)) ? GS_W'(GRID) : cfg.grid_size;
		p  = (32'(cfg.padded_bins) > MAX_BINS) ? PB_W'(MAX_BINS) : cfg.padded_bins;
		ac = ang_q + 16'd16384;
		qs = ang_q[15:14];
		qc = ac[15:14];
		zs = qs[0] ? (15'd16384 - {1'b0, ang_q[13:0]}) : {1'b0, ang_q[13:0]};
		zc = qc[0] ? (15'd16384 - {1'b0, ac[13:0]}) : {1'b0, ac[13:0]};
		zzs = zs * zs;
		zzc = zc * zc;
		czs = SIN_C * z2s_q;
		czc = SIN_C * z2c_q;
		tzs = ts_q * z2s_q;
		tzc = tc_q * z2c_q;
		vzs = ts_q * zs_q;
		vzc = tc_q * zc_q;
		vs  = qs[1] ? -$signed({1'b0, vzs[30:14]}) : $signed({1'b0, vzs[30:14]});
		vc  = qc[1] ? -$signed({1'b0, vzc[30:14]}) : $signed({1'b0, vzc[30:14]});
		s_w = S_W'($signed({1'b0, det_q, 16'd0}))
		    - ((S_W'($signed({1'b0, p})) - S_W'(1)) <<< 15)
		    + S_W'(cfg.ray_offset);
		gl_w = CW'($signed({1'b0, n_q, 16'd0}) - $signed({2'b00, g, 15'd0}));
		half_w = NUM_W'($signed({1'b0, g, 15'd0}));
		numa = NUM_W'(pa_q) - (NUM_W'(s_q) <<< 16);
		numb = NUM_W'(pb_q) + (NUM_W'(s_q) <<< 16);
		in_rng = (div_q > -half_w) && (div_q < half_w);
	end

	assign div_start = (state_q == ST_DA && sn_q != '0) || (state_q == ST_DB && cs_q != '0);
	assign div_num   = (state_q == ST_DA) ? numa : numb;
	assign div_den   = (state_q == ST_DA) ? sn_q : cs_q;

	prgt_div #(.NW(NUM_W), .DW(TRIG_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_q)
	);

	// crossing memories
	logic             wea, web;
	logic [CNW-1:0]   addr_a;
	logic             rev;

	assign rev    = ang_q[14];
	assign wea    = (state_q == ST_WA) && div_done && in_rng;
	assign web    = (state_q == ST_WB) && div_done && in_rng;
	assign addr_a = rev ? (alen_q - CNW'(1) - i_q) : i_q;

	always_ff @(posedge clk) begin
		if (wea)
			mem_a[alen_q[IW-1:0]] <= {div_q[CW-1:0], gl_q};
		if (web)
			mem_b[blen_q[IW-1:0]] <= {gl_q, div_q[CW-1:0]};
		rda_q <= mem_a[addr_a[IW-1:0]];
		rdb_q <= mem_b[j_q[IW-1:0]];
	end

	// merge pick and segment geometry
	logic signed [CW-1:0]  ax, bx, cx, cy;
	logic                  take_a, first;
	logic [CNW:0]          len_w, k_next;
	logic signed [CW:0]    dx, dy;
	logic [CLW-1:0]        colc, rowc;
	logic [GS_W-1:0]       col, row;
	logic [2*GS_W-1:0]     pix_w;
	logic                  sq_start, sq_done;
	logic [RTW-1:0]        root;
	logic [RTW:0]          lr;
	logic [LEN_W-1:0]      seg;

	always_comb begin
		ax     = $signed(rda_q[2*CW-1:CW]);
		bx     = $signed(rdb_q[2*CW-1:CW]);
		take_a = (i_q < alen_q) && ((j_q >= blen_q) || (ax < bx));
		cx     = take_a ? ax : bx;
		cy     = take_a ? $signed(rda_q[CW-1:0]) : $signed(rdb_q[CW-1:0]);
		len_w  = (CNW + 1)'(alen_q) + (CNW + 1)'(blen_q);
		k_next = (CNW + 1)'(i_q) + (CNW + 1)'(j_q) + (CNW + 1)'(1);
		first  = (i_q == '0) && (j_q == '0);
		dx     = (CW + 1)'(cx) - (CW + 1)'(px_q);
		dy     = (CW + 1)'(cy) - (CW + 1)'(py_q);
		colc   = smx_q[SMW-1:17];
		rowc   = smy_q[SMW-1:17];
		if (smx_q <= 0 || g == '0)
			col = '0;
		else if (32'(colc) > 32'(g) - 1)
			col = g - GS_W'(1);
		else
			col = GS_W'(colc);
		if (smy_q <= 0 || g == '0)
			row = '0;
		else if (32'(rowc) > 32'(g) - 1)
			row = g - GS_W'(1);
		else
			row = GS_W'(rowc);
		pix_w  = (2 * GS_W)'(col) + row * g;
		lr     = (RTW + 1)'(root) + (RTW + 1)'(2);
		seg    = (lr[RTW:2] > (RTW - 1)'(16'hFFFF)) ? 16'hFFFF : lr[17:2];
	end

	assign sq_start = (state_q == ST_RT_GO);

	prgt_isqrt #(.W(SQW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.val    (sq_q),
		.done   (sq_done),
		.root   (root)
	);

	// sequencer
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_n = ST_T1;
			ST_T1:      state_n = ST_T2;
			ST_T2:      state_n = ST_T3;
			ST_T3:      state_n = ST_T4;
			ST_T4:      state_n = ST_MUL;
			ST_MUL:     state_n = ST_DA;
			ST_DA:      state_n = (sn_q != '0) ? ST_WA : ST_DB;
			ST_WA:      if (div_done) state_n = ST_DB;
			ST_DB:      state_n = (cs_q != '0) ? ST_WB : ST_NEXT;
			ST_WB:      if (div_done) state_n = ST_NEXT;
			ST_NEXT: begin
				if (n_q != g)
					state_n = ST_MUL;
				else if (len_w < (CNW + 1)'(2))
					state_n = ST_EMPTY;
				else
					state_n = ST_FETCH;
			end
			ST_FETCH:   state_n = ST_PICK;
			ST_PICK:    state_n = first ? ST_FETCH : ST_SQ;
			ST_SQ:      state_n = ST_RT_GO;
			ST_RT_GO:   state_n = ST_RT_WAIT;
			ST_RT_WAIT: if (sq_done) state_n = ST_OUT;
			ST_OUT:     if (res_ready) state_n = lastseg_q ? ST_IDLE : ST_FETCH;
			ST_EMPTY:   if (res_ready) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			alen_q  <= '0;
			blen_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE) begin
				n_q    <= '0;
				alen_q <= '0;
				blen_q <= '0;
				i_q    <= '0;
				j_q    <= '0;
			end
			if (wea)
				alen_q <= alen_q + CNW'(1);
			if (web)
				blen_q <= blen_q + CNW'(1);
			if (state_q == ST_NEXT && n_q != g)
				n_q <= n_q + GS_W'(1);
			if (state_q == ST_PICK) begin
				if (take_a)
					i_q <= i_q + CNW'(1);
				else
					j_q <= j_q + CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ang_q <= angle;
				det_q <= detector_index;
			end
			ST_T1: begin
				zs_q  <= zs;
				zc_q  <= zc;
				z2s_q <= zzs[28:14];
				z2c_q <= zzc[28:14];
			end
			ST_T2: begin
				ts_q <= 17'(SIN_B) - 17'(czs[27:14]);
				tc_q <= 17'(SIN_B) - 17'(czc[27:14]);
			end
			ST_T3: begin
				ts_q <= 17'(18'(SIN_A) - tzs[31:14]);
				tc_q <= 17'(18'(SIN_A) - tzc[31:14]);
			end
			ST_T4: begin
				sn_q <= vs;
				cs_q <= vc;
				s_q  <= s_w;
			end
			ST_MUL: begin
				gl_q <= gl_w;
				pa_q <= gl_w * cs_q;
				pb_q <= gl_w * sn_q;
			end
			ST_PICK: begin
				px_q      <= cx;
				py_q      <= cy;
				ux_q      <= CW'(dx[CW] ? -dx : dx);
				uy_q      <= CW'(dy[CW] ? -dy : dy);
				smx_q     <= SMW'(px_q) + SMW'(cx) + SMW'($signed({1'b0, g, 16'd0}));
				smy_q     <= SMW'(py_q) + SMW'(cy) + SMW'($signed({1'b0, g, 16'd0}));
				lastseg_q <= (k_next == len_w);
			end
			ST_SQ: begin
				sq_q  <= SQW'(ux_q * ux_q) + SQW'(uy_q * uy_q);
				pix_q <= pix_w[PIX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT) || (state_q == ST_EMPTY);

	always_comb begin
		if (state_q == ST_EMPTY) begin
			res.pixel_index = '0;
			res.seg_length  = '0;
			res.last        = 1'b1;
			res.empty_res   = 1'b1;
		end else begin
			res.pixel_index = pix_q;
			res.seg_length  = seg;
			res.last        = lastseg_q;
			res.empty_res   = 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: sv/parallel_ray_grid_tracer.sv
// throughput: one ray at a time; the scan is set by the shared 48-step divider,
// each segment by the 22-step square root unit
// results leave through an output register, so a new ray starts while the last waits
// reset: asynchronous, active low; configuration returns to 16, 23 and 655
// ----------------------------------------------------------------------------
// parallel_ray_grid_tracer
// parallel beam ray tracer through a square pixel grid, one beat per segment
// ----------------------------------------------------------------------------
`default_nettype none
module parallel_ray_grid_tracer #(
	parameter int GRID = prgt_pkg::GRID_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [prgt_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [prgt_pkg::CFG_DW-1:0]  cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [prgt_pkg::ANG_W-1:0]   angle,
	input  wire logic [prgt_pkg::DET_W-1:0]   detector_index,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [prgt_pkg::PIX_W-1:0]        pixel_index,
	output logic [prgt_pkg::LEN_W-1:0]        seg_length,
	output logic                              last,
	output logic                              empty_res
);
	import prgt_pkg::*;

	cfg_t cfg_q;
	res_t res, out_q;
	logic res_valid, slot_free, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_size   <= GRID_SIZE_RST;
			cfg_q.padded_bins <= PADDED_BINS_RST;
			cfg_q.ray_offset  <= RAY_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SIZE:   cfg_q.grid_size   <= cfg_data[GS_W-1:0];
				REG_PADDED_BINS: cfg_q.padded_bins <= cfg_data[PB_W-1:0];
				REG_RAY_OFFSET:  cfg_q.ray_offset  <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	prgt_core #(.GRID(GRID)) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.angle          (angle),
		.detector_index (detector_index),
		.cfg            (cfg_q),
		.res_valid      (res_valid),
		.res_ready      (slot_free),
		.res            (res)
	);

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && slot_free)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free)
			out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = out_q.pixel_index;
	assign seg_length  = out_q.seg_length;
	assign last        = out_q.last;
	assign empty_res   = out_q.empty_res;
endmodule
`default_nettype wire

// File: sv/prgt_checker.sv
// ----------------------------------------------------------------------------
// prgt_checker
// port level checks of the parallel ray grid tracer
// ----------------------------------------------------------------------------
`default_nettype none
module prgt_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cfg_we,
	input wire logic [prgt_pkg::CFG_IW-1:0]  cfg_index,
	input wire logic [prgt_pkg::CFG_DW-1:0]  cfg_data,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic [prgt_pkg::ANG_W-1:0]   angle,
	input wire logic [prgt_pkg::DET_W-1:0]   detector_index,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [prgt_pkg::PIX_W-1:0]   pixel_index,
	input wire logic [prgt_pkg::LEN_W-1:0]   seg_length,
	input wire logic                         last,
	input wire logic                         empty_res
);
	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_index)
		&& $stable(seg_length) && $stable(last) && $stable(empty_res))
		else $error("stalled output beat changed");

	// an empty ray is a single final beat
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last)
		else $error("empty beat not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> pixel_index == '0 && seg_length == '0)
		else $error("empty beat carries data");

	// a ray in flight blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a ray is traced");
endmodule

bind parallel_ray_grid_tracer prgt_checker u_prgt_checker (.*);
`default_nettype wire

// File: sim/tb_parallel_ray_grid_tracer.sv
// ----------------------------------------------------------------------------
// tb_parallel_ray_grid_tracer
// self-checking bench: rays go in through a valid/ready channel with random
// gaps, and each segment beat that comes out is compared with a bit-exact
// fixed-point ray trace kept in the bench, across several grid settings
// ----------------------------------------------------------------------------
`default_nettype none
module tb_parallel_ray_grid_tracer;
	import prgt_pkg::*;

	localparam longint CYCLE_LIMIT = 12000000;
	localparam int GMAX = GRID_DEF;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [ANG_W-1:0] angle;
	logic [DET_W-1:0] detector_index;
	logic out_valid;
	logic out_ready;
	logic [PIX_W-1:0] pixel_index;
	logic [LEN_W-1:0] seg_length;
	logic last;
	logic empty_res;

	logic [GS_W-1:0] cur_grid;
	logic [PB_W-1:0] cur_bins;
	logic signed [OFS_W-1:0] cur_offset;

	res_t seg_q[$];
	int errors;
	int hold_cycles;
	bit rx_no_idle;
	bit tx_no_idle;
	longint cycles;

	parallel_ray_grid_tracer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle(angle), .detector_index(detector_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_index(pixel_index), .seg_length(seg_length),
		.last(last), .empty_res(empty_res)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// quarter-wave polynomial sine, Q16
	function automatic longint sin_q16(logic [15:0] a);
		longint unsigned z, z2, t;
		logic [1:0] q;
		q = a[15:14];
		z = q[0] ? (64'd16384 - a[13:0]) : a[13:0];
		z2 = (z * z) >> 14;
		t = (64'd4640 * z2) >> 14;
		t = 64'd42048 - t;
		t = (t * z2) >> 14;
		t = 64'd102944 - t;
		t = (t * z) >> 14;
		return q[1] ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint pixel_cell(longint sum, longint g);
		longint c;
		if (sum <= 0 || g == 0) return 0;
		c = sum / 131072;
		if (c > g - 1) c = g - 1;
		return c;
	endfunction

	// trace one ray and queue its segments
	task automatic trace_ray(logic [15:0] ang, logic [5:0] det);
		longint hx[GMAX+1], hy[GMAX+1], vx[GMAX+1], vy[GMAX+1];
		longint mx[2*GMAX+2], my[2*GMAX+2];
		longint g, p, sn, cs, s, half, gl, x, y, dx, dy, col, row;
		longint unsigned l;
		int hn, vn, n, i, j, k, hi;
		bit rev;
		res_t r;
		g = (cur_grid > GMAX) ? GMAX : cur_grid;
		p = (cur_bins > MAX_BINS) ? MAX_BINS : cur_bins;
		sn = sin_q16(ang);
		cs = sin_q16(ang + 16'd16384);
		s = longint'(det) * 65536 - (p - 1) * 32768 + longint'(cur_offset);
		half = g * 32768;
		rev = ang[14];
		hn = 0;
		vn = 0;
		for (n = 0; n <= g; n++) begin
			gl = n * 65536 - half;
			if (sn != 0) begin
				x = (gl * cs - s * 65536) / sn;
				if (x > -half && x < half) begin
					hx[hn] = x;
					hy[hn] = gl;
					hn++;
				end
			end
			if (cs != 0) begin
				y = (gl * sn + s * 65536) / cs;
				if (y > -half && y < half) begin
					vx[vn] = gl;
					vy[vn] = y;
					vn++;
				end
			end
		end
		i = 0;
		j = 0;
		k = 0;
		while (i < hn || j < vn) begin
			hi = rev ? (hn - 1 - i) : i;
			if (i < hn && (j >= vn || hx[hi] < vx[j])) begin
				mx[k] = hx[hi];
				my[k] = hy[hi];
				i++;
			end else begin
				mx[k] = vx[j];
				my[k] = vy[j];
				j++;
			end
			k++;
		end
		if (k < 2) begin
			r = '{pixel_index: 0, seg_length: 0, last: 1'b1, empty_res: 1'b1};
			seg_q.push_back(r);
			return;
		end
		for (n = 0; n < k - 1; n++) begin
			dx = mx[n+1] - mx[n];
			dy = my[n+1] - my[n];
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			l = (int_sqrt(dx * dx + dy * dy) + 2) >> 2;
			if (l > 65535) l = 65535;
			col = pixel_cell(mx[n] + mx[n+1] + g * 65536, g);
			row = pixel_cell(my[n] + my[n+1] + g * 65536, g);
			r.pixel_index = PIX_W'(col + row * g);
			r.seg_length = LEN_W'(l);
			r.last = (n == k - 2);
			r.empty_res = 1'b0;
			seg_q.push_back(r);
		end
	endtask

	task automatic report(string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// segment beat checker
	initial begin
		res_t e;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (seg_q.size() == 0) begin
					report("segment beat with none expected");
				end else begin
					e = seg_q.pop_front();
					if (pixel_index !== e.pixel_index)
						report($sformatf("pixel_index %0d, expected %0d",
							pixel_index, e.pixel_index));
					if (seg_length !== e.seg_length)
						report($sformatf("seg_length %0d, expected %0d",
							seg_length, e.seg_length));
					if (last !== e.last)
						report($sformatf("last %0b, expected %0b", last, e.last));
					if (empty_res !== e.empty_res)
						report($sformatf("empty_res %0b, expected %0b",
							empty_res, e.empty_res));
				end
			end
		end
	end

	// receiver with random stalls and an optional long hold-off
	initial begin
		int w;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			w = rx_no_idle ? 0 : $urandom_range(0, 12);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_ray(logic [15:0] ang, logic [5:0] det);
		int w;
		w = tx_no_idle ? 0 : $urandom_range(0, 12);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		angle <= ang;
		detector_index <= det;
		do @(posedge clk); while (!in_ready);
		trace_ray(ang, det);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (seg_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_config(logic [GS_W-1:0] g, logic [PB_W-1:0] p,
			logic signed [OFS_W-1:0] o);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_SIZE;
		cfg_data <= CFG_DW'(g);
		@(posedge clk);
		cfg_index <= REG_PADDED_BINS;
		cfg_data <= CFG_DW'(p);
		@(posedge clk);
		cfg_index <= REG_RAY_OFFSET;
		cfg_data <= o;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_grid = g;
		cur_bins = p;
		cur_offset = o;
		@(posedge clk);
	endtask

	task automatic test_axis_and_edges();
		logic [15:0] angs[10] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535,
			16'd1, 16'd8192, 16'd24576, 16'd40960, 16'd57344};
		foreach (angs[i]) send_ray(angs[i], 6'd11);
		send_ray(16'd5000, 6'd0);
		send_ray(16'd5000, 6'd63);
		send_ray(16'd20000, 6'd22);
		send_ray(16'd45000, 6'd3);
		send_ray(16'd60000, 6'd18);
		drain();
	endtask

	task automatic test_config_extremes();
		logic signed [OFS_W-1:0] big;
		big = 28'sd67108864;
		set_config(5'd0, 7'd23, 28'sd655);
		send_ray(16'd3000, 6'd11);
		send_ray(16'd0, 6'd11);
		drain();
		set_config(5'd1, 7'd1, 28'sd0);
		send_ray(16'd3000, 6'd0);
		send_ray(16'd16384, 6'd0);
		drain();
		set_config(5'd2, 7'd0, 28'sd32768);
		send_ray(16'd7000, 6'd0);
		send_ray(16'd39000, 6'd1);
		drain();
		set_config(5'd31, 7'd127, 28'sd655);
		send_ray(16'd12000, 6'd63);
		send_ray(16'd52000, 6'd40);
		drain();
		set_config(5'd16, 7'd64, -big);
		send_ray(16'd9000, 6'd63);
		drain();
		set_config(5'd16, 7'd64, big);
		send_ray(16'd9000, 6'd0);
		drain();
	endtask

	task automatic test_output_backpressure();
		set_config(5'd4, 7'd8, 28'sd655);
		tx_no_idle = 1;
		hold_cycles = 4000;
		repeat (8) send_ray(16'($urandom), 6'($urandom_range(0, 7)));
		tx_no_idle = 0;
		drain();
	endtask

	task automatic test_random_rays(int phases, int per_phase);
		int g, p, span;
		for (int ph = 0; ph < phases; ph++) begin
			g = $urandom_range(2, 16);
			p = $urandom_range(1, 64);
			set_config(GS_W'(g), PB_W'(p),
				OFS_W'($signed($urandom_range(0, 262144)) - 131072));
			rx_no_idle = (ph == 1);
			tx_no_idle = (ph == 1) || (ph == 3);
			span = (p + g > 63) ? 63 : p + g;
			for (int n = 0; n < per_phase; n++) begin
				if ($urandom_range(0, 9) == 0)
					send_ray(16'($urandom), 6'($urandom));
				else
					send_ray(16'($urandom), 6'($urandom_range(0, span)));
			end
			rx_no_idle = 0;
			tx_no_idle = 0;
			drain();
		end
	endtask

	initial begin
		errors = 0;
		hold_cycles = 0;
		rx_no_idle = 0;
		tx_no_idle = 0;
		cur_grid = GRID_SIZE_RST;
		cur_bins = PADDED_BINS_RST;
		cur_offset = RAY_OFFSET_RST;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GRID_SIZE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		angle <= '0;
		detector_index <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_axis_and_edges();
		test_config_extremes();
		test_output_backpressure();
		test_random_rays(6, 50);
		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
